[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion helpers for the diagonal morphology block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DBM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbm assertion failed");

// next-cycle implication, disabled while reset is low
`define DBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbm assertion failed");

`endif

[hw/rtl/dbm_pkg.sv]
// ---------------------------------------------------------------------------
// dbm_pkg
// shared types and constants of the diagonal binary morphology block
// ---------------------------------------------------------------------------
`default_nettype none

package dbm_pkg;

    // pixel and line store word
    localparam int PIX_W  = 8;
    localparam int LINE_W = 2 * PIX_W;

    // configuration port
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_W_BITS   = 11;
    localparam int CFG_H_BITS   = 13;
    localparam int CFG_SIZE_RST = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_PAINT_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // request opcodes
    localparam logic OP_PIXEL = 1'b0;

    // trigger values per paint mode
    localparam logic [PIX_W-1:0] TRIG_MODE0 = 8'hFF;
    localparam logic [PIX_W-1:0] TRIG_MODE1 = 8'h00;

    // output queue
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW    = 2;
    localparam int OFIFO_CW    = 3;

    // command from the sequencer to the window stage
    typedef struct packed {
        logic             vld;        // line store was read for this request
        logic             wr;         // pixel request, line store is written
        logic             em;         // a result leaves for this request
        logic             first_pix;  // first pixel of the image
        logic             top_cl;     // result row is the first row
        logic             bot_cl;     // result row is the last row
        logic             left_cl;    // result column is the first column
        logic             right_cl;   // result column is the last column
        logic             first_ovr;  // single-row image, first column
        logic             last;       // result closes the image
        logic [PIX_W-1:0] pix;
    } t_cmd;

    // one column of the window: rows above, at and below the result row
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col;

    // one result
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_res;

endpackage

`default_nettype wire

[hw/rtl/dbm_ram.sv]
// ---------------------------------------------------------------------------
// dbm_ram
// generic single-clock ram, one write and one read port, registered read
// ---------------------------------------------------------------------------
`default_nettype none

module dbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dbm_ctrl.sv]
// ---------------------------------------------------------------------------
// dbm_ctrl
// configuration registers, raster counters and request sequencing
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dbm_ctrl
    import dbm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_op,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  logic [OFIFO_CW-1:0]   i_fifo_cnt,
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_addr,
    output t_cmd                  o_cmd,
    output logic [AW-1:0]         o_cmd_addr,
    output logic                  o_paint_mode
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int RST_W = (CFG_SIZE_RST > MAX_WIDTH) ? MAX_WIDTH : CFG_SIZE_RST;
    localparam int RST_H = (CFG_SIZE_RST > MAX_HEIGHT) ? MAX_HEIGHT : CFG_SIZE_RST;

    logic          r_paint_mode, n_paint_mode;
    logic [WW-1:0] r_w, n_w;
    logic [HW-1:0] r_h, n_h;
    logic [AW-1:0] r_in_col, n_in_col;
    logic [RW-1:0] r_in_row, n_in_row;
    logic          r_in_done, n_in_done;
    logic [PW-1:0] r_pend, n_pend;
    logic [AW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;
    t_cmd          r_cmd, n_cmd;
    logic [AW-1:0] r_cmd_addr;

    logic [31:0]   w_cfg_w_raw, w_cfg_h_raw;
    logic [WW-1:0] w_cfg_w;
    logic [HW-1:0] w_cfg_h;
    logic [AW-1:0] w_col_last, w_out_col_next;
    logic [RW-1:0] w_row_last;
    logic [PW-1:0] w_pend_full;
    logic          w_acc, w_is_pix, w_pix_emit, w_emit, w_rd, w_last;
    logic          w_in_col_end, w_in_row_end, w_out_col_end;

    // size clamping of written values
    assign w_cfg_w_raw = 32'(i_cfg_data[CFG_W_BITS-1:0]);
    assign w_cfg_h_raw = 32'(i_cfg_data[CFG_H_BITS-1:0]);
    assign w_cfg_w = (w_cfg_w_raw == 32'd0) ? WW'(1) :
                     (w_cfg_w_raw > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_cfg_w_raw);
    assign w_cfg_h = (w_cfg_h_raw == 32'd0) ? HW'(1) :
                     (w_cfg_h_raw > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(w_cfg_h_raw);

    // register write decode
    always_comb begin
        n_paint_mode = r_paint_mode;
        n_w          = r_w;
        n_h          = r_h;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PAINT_MODE:   n_paint_mode = i_cfg_data[0];
                CFG_IMAGE_WIDTH:  n_w = w_cfg_w;
                CFG_IMAGE_HEIGHT: n_h = w_cfg_h;
                default: ;
            endcase
        end
    end

    // image geometry
    assign w_col_last  = AW'(r_w - WW'(1));
    assign w_row_last  = RW'(r_h - HW'(1));
    assign w_pend_full = PW'(r_w) + PW'(1);

    // request classification
    assign o_in_ready     = (i_fifo_cnt + OFIFO_CW'(r_cmd.em)) < OFIFO_CW'(OFIFO_DEPTH);
    assign w_acc          = i_in_valid && o_in_ready;
    assign w_is_pix       = !r_in_done && (i_op == OP_PIXEL);
    assign w_pix_emit     = w_is_pix && (r_pend == w_pend_full);
    assign w_emit         = w_pix_emit || r_in_done;
    assign w_rd           = w_is_pix || r_in_done;
    assign w_last         = r_in_done && (r_pend == PW'(1));
    assign w_in_col_end   = (r_in_col == w_col_last);
    assign w_in_row_end   = (r_in_row == w_row_last);
    assign w_out_col_end  = (r_out_col == w_col_last);
    assign w_out_col_next = w_out_col_end ? '0 : r_out_col + AW'(1);

    // line store read: pixel column, or the column after the result for a drain
    assign o_rd_en   = w_acc && w_rd;
    assign o_rd_addr = w_is_pix ? r_in_col : w_out_col_next;

    // counter updates
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_done = r_in_done;
        n_pend    = r_pend;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (w_acc && w_is_pix) begin
            if (w_in_col_end) begin
                n_in_col = '0;
                if (w_in_row_end) begin
                    n_in_row  = '0;
                    n_in_done = 1'b1;
                end else begin
                    n_in_row = r_in_row + RW'(1);
                end
            end else begin
                n_in_col = r_in_col + AW'(1);
            end
            if (!w_pix_emit) begin
                n_pend = r_pend + PW'(1);
            end
        end
        if (w_acc && r_in_done) begin
            n_pend = r_pend - PW'(1);
            if (w_last) begin
                n_in_done = 1'b0;
            end
        end
        if (w_acc && w_emit) begin
            if (w_last) begin
                n_out_col = '0;
                n_out_row = '0;
            end else if (w_out_col_end) begin
                n_out_col = '0;
                n_out_row = r_out_row + RW'(1);
            end else begin
                n_out_col = w_out_col_next;
            end
        end
    end

    // command for the window stage
    always_comb begin
        n_cmd.vld       = w_acc && w_rd;
        n_cmd.wr        = w_acc && w_is_pix;
        n_cmd.em        = w_acc && w_emit;
        n_cmd.first_pix = w_acc && w_is_pix && (r_in_col == '0) && (r_in_row == '0);
        n_cmd.top_cl    = (r_out_row == '0);
        n_cmd.bot_cl    = (r_out_row == w_row_last);
        n_cmd.left_cl   = (r_out_col == '0);
        n_cmd.right_cl  = w_out_col_end;
        n_cmd.first_ovr = (w_row_last == '0) && (r_out_col == '0);
        n_cmd.last      = w_last;
        n_cmd.pix       = i_pixel_in;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paint_mode <= 1'b0;
            r_w          <= WW'(RST_W);
            r_h          <= HW'(RST_H);
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_in_done    <= 1'b0;
            r_pend       <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_cmd        <= '0;
        end else begin
            r_paint_mode <= n_paint_mode;
            r_w          <= n_w;
            r_h          <= n_h;
            r_in_col     <= n_in_col;
            r_in_row     <= n_in_row;
            r_in_done    <= n_in_done;
            r_pend       <= n_pend;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            r_cmd        <= n_cmd;
        end
    end

    // command address, payload only
    always_ff @(posedge i_clk) begin
        r_cmd_addr <= o_rd_addr;
    end

    assign o_cmd        = r_cmd;
    assign o_cmd_addr   = r_cmd_addr;
    assign o_paint_mode = r_paint_mode;

    // the closing result returns the sequencer to the start of an image
    `DBM_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, w_acc && w_last,
        (r_pend == '0) && !r_in_done && (r_out_col == '0) && (r_out_row == '0))
    // a complete image always has results outstanding
    `DBM_ASSERT_IMPL(a_done_pending, i_clk, i_rst_n, r_in_done, r_pend != '0)

endmodule

`default_nettype wire

[hw/rtl/dbm_window.sv]
// ---------------------------------------------------------------------------
// dbm_window
// line store read-modify-write, 3x3 window columns and diagonal test
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dbm_window
    import dbm_pkg::*;
#(
    parameter int AW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [AW-1:0]     i_cmd_addr,
    input  logic              i_req_en,
    input  logic [AW-1:0]     i_req_addr,
    input  logic [LINE_W-1:0] i_rd_data,
    input  logic              i_paint_mode,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [LINE_W-1:0] o_wr_data,
    output logic              o_push,
    output t_res              o_result
);

    t_col              r_p0, r_p1;
    logic [PIX_W-1:0]  r_first;
    logic              r_fwd;
    logic [LINE_W-1:0] r_fwd_data;

    logic [LINE_W-1:0] w_line;
    t_col              w_new, w_center, w_left, w_right;
    logic [PIX_W-1:0]  w_trig;
    logic              w_fwd, w_hit;

    // true when a clamped column holds the trigger above or below the result row
    function automatic logic col_hit(input t_col c, input logic top_cl, input logic bot_cl,
                                     input logic [PIX_W-1:0] trig);
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] dn;
        up = top_cl ? c.mid : c.top;
        dn = bot_cl ? c.mid : c.bot;
        return (up == trig) || (dn == trig);
    endfunction

    // line data, forwarded when the previous request wrote the same column
    assign w_line    = r_fwd ? r_fwd_data : i_rd_data;
    assign w_new.top = w_line[LINE_W-1:PIX_W];
    assign w_new.mid = w_line[PIX_W-1:0];
    assign w_new.bot = i_cmd.pix;

    // write back: the newer row ages, the pixel becomes the newer row
    assign o_wr_en   = i_cmd.vld && i_cmd.wr;
    assign o_wr_addr = i_cmd_addr;
    assign o_wr_data = {w_new.mid, i_cmd.pix};
    assign w_fwd     = i_req_en && o_wr_en && (i_req_addr == i_cmd_addr);

    // window columns with edge clamping
    always_comb begin
        if (i_cmd.first_ovr) begin
            w_center.top = r_first;
            w_center.mid = r_first;
            w_center.bot = r_first;
        end else begin
            w_center = r_p0;
        end
        w_left  = i_cmd.left_cl ? w_center : r_p1;
        w_right = i_cmd.right_cl ? w_center : w_new;
    end

    // diagonal test
    assign w_trig = i_paint_mode ? TRIG_MODE1 : TRIG_MODE0;
    assign w_hit  = col_hit(w_left, i_cmd.top_cl, i_cmd.bot_cl, w_trig) ||
                    col_hit(w_right, i_cmd.top_cl, i_cmd.bot_cl, w_trig);

    assign o_push          = i_cmd.em;
    assign o_result.pixel  = w_hit ? w_trig : w_center.mid;
    assign o_result.last   = i_cmd.last;

    // window shift and first pixel capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0    <= '0;
            r_p1    <= '0;
            r_first <= '0;
            r_fwd   <= 1'b0;
        end else begin
            r_fwd <= w_fwd;
            if (i_cmd.vld) begin
                r_p1 <= w_center;
                r_p0 <= w_new;
            end
            if (i_cmd.first_pix) begin
                r_first <= i_cmd.pix;
            end
        end
    end

    // forwarded line word
    always_ff @(posedge i_clk) begin
        r_fwd_data <= o_wr_data;
    end

    // forwarding is only armed by a write in the cycle before
    `DBM_ASSERT_NEXT(a_fwd_source, i_clk, i_rst_n, !o_wr_en, !r_fwd)
    // a result always comes with a line store read
    `DBM_ASSERT_IMPL(a_push_read, i_clk, i_rst_n, o_push, i_cmd.vld)

endmodule

`default_nettype wire

[hw/rtl/dbm_ofifo.sv]
// ---------------------------------------------------------------------------
// dbm_ofifo
// small result queue between the window stage and the output channel
// ---------------------------------------------------------------------------
`default_nettype none

module dbm_ofifo
    import dbm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_res                i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output t_res                o_data,
    output logic [OFIFO_CW-1:0] o_count
);

    t_res                r_mem [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [OFIFO_CW-1:0] r_cnt, n_cnt;
    logic                w_pop;

    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && i_ready;
    assign n_cnt   = r_cnt + OFIFO_CW'(i_push) - OFIFO_CW'(w_pop);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_cnt;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OFIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + OFIFO_AW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/diagonal_binary_morphology.sv]
// ---------------------------------------------------------------------------
// diagonal_binary_morphology
// 3x3 diagonal binary dilation over a raster pixel stream with line stores
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_ready   i_op, i_pixel_in
//   out       output     o_out_valid / i_out_ready o_pixel_out, o_frame_last
//   cfg       input      i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// one request per cycle while ready is high; a result is queued in the cycle after its request
// the line store read-modify-write of one column per cycle sets the rate
// results trail their pixel by one row plus one pixel; drain requests flush
// ready falls when the four-entry result queue plus the result in flight is full
// reset clears counters and window, the line store needs no clearing pass
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module diagonal_binary_morphology
    import dbm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_op,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic [LINE_W-1:0]   w_rd_data;
    t_cmd                w_cmd;
    logic [AW-1:0]       w_cmd_addr;
    logic                w_paint_mode;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [LINE_W-1:0]   w_wr_data;
    logic                w_push;
    t_res                w_result;
    t_res                w_out;
    logic [OFIFO_CW-1:0] w_fifo_cnt;

    // sequencer
    dbm_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_pixel_in   (i_pixel_in),
        .i_fifo_cnt   (w_fifo_cnt),
        .o_rd_en      (w_rd_en),
        .o_rd_addr    (w_rd_addr),
        .o_cmd        (w_cmd),
        .o_cmd_addr   (w_cmd_addr),
        .o_paint_mode (w_paint_mode)
    );

    // line store: older row in the upper byte, newer row in the lower byte
    dbm_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // window and diagonal test
    dbm_window #(
        .AW (AW)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cmd_addr   (w_cmd_addr),
        .i_req_en     (w_rd_en),
        .i_req_addr   (w_rd_addr),
        .i_rd_data    (w_rd_data),
        .i_paint_mode (w_paint_mode),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .o_push       (w_push),
        .o_result     (w_result)
    );

    // result queue
    dbm_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_out),
        .o_count (w_fifo_cnt)
    );

    assign o_pixel_out  = w_out.pixel;
    assign o_frame_last = w_out.last;

    // the credit check keeps the result queue from overflowing
    `DBM_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, w_push,
        w_fifo_cnt != OFIFO_CW'(OFIFO_DEPTH))

endmodule

`default_nettype wire

[sim/dbm_result_checker.sv]
// ----------------------------------------------------------------------------
// dbm_result_checker
// Follows the request, result and register traffic of the diagonal morphology
// block. It keeps its own line history and position counters, predicts each
// result in raster order and compares every result field by field.
// ----------------------------------------------------------------------------
module dbm_result_checker
    import dbm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_op,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [PIX_W-1:0]      i_pixel_out,
    input  logic                  i_frame_last,
    output int                    o_waiting,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // history of the most recent pixels, two rows plus the window
    localparam int HIST_LEN = 2 * MAX_WIDTH + 9;

    logic [PIX_W-1:0]      pix_hist [HIST_LEN];
    logic                  spread_zero;
    logic [CFG_W_BITS-1:0] width_reg;
    logic [CFG_H_BITS-1:0] height_reg;
    int unsigned           next_col;
    int unsigned           next_row;
    int unsigned           in_flight;
    t_res                  dilated_q [$];
    t_res                  want;

    // register value as the block uses it
    function automatic int unsigned fit(input int unsigned v, input int unsigned lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic [PIX_W-1:0] hist_at(input int unsigned idx);
        return pix_hist[idx % HIST_LEN];
    endfunction

    // oldest pending pixel: keep it or paint it from its diagonal neighbors
    task automatic release_result(input int unsigned w, input int unsigned h,
                                  input int unsigned total);
        int unsigned      pos, j, r, c, ru, rd, cl, cr;
        logic [PIX_W-1:0] trig;
        logic             hit;
        t_res             res;
        pos  = next_row * w + next_col;
        j    = (pos >= in_flight) ? pos - in_flight : 0;
        r    = j / w;
        c    = j % w;
        ru   = (r > 0) ? r - 1 : 0;
        rd   = (r + 1 < h) ? r + 1 : h - 1;
        cl   = (c > 0) ? c - 1 : 0;
        cr   = (c + 1 < w) ? c + 1 : w - 1;
        trig = spread_zero ? TRIG_MODE1 : TRIG_MODE0;
        hit  = (hist_at(ru * w + cl) == trig) || (hist_at(ru * w + cr) == trig) ||
               (hist_at(rd * w + cl) == trig) || (hist_at(rd * w + cr) == trig);
        in_flight--;
        res.pixel = hit ? trig : hist_at(j);
        res.last  = (pos >= total) && (in_flight == 0);
        if (res.last) begin
            next_col = 0;
            next_row = 0;
        end
        dilated_q.push_back(res);
    endtask

    // one accepted request
    task automatic take_request(input logic op, input logic [PIX_W-1:0] pix);
        int unsigned w, h, total, pos;
        w     = fit(width_reg, MAX_WIDTH);
        h     = fit(height_reg, MAX_HEIGHT);
        total = w * h;
        pos   = next_row * w + next_col;
        // image fully given out: next pixel starts a new one
        if (pos >= total && in_flight == 0) begin
            next_col = 0;
            next_row = 0;
            pos      = 0;
        end
        if (pos < total) begin
            if (op == OP_PIXEL) begin
                pix_hist[pos % HIST_LEN] = pix;
                next_col++;
                if (next_col >= w) begin
                    next_col = 0;
                    next_row++;
                end
                in_flight++;
                if (in_flight > w + 1) release_result(w, h, total);
            end
        end else if (in_flight != 0) begin
            // drain, or surplus pixel acting as one
            release_result(w, h, total);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (pix_hist[k]) pix_hist[k] = '0;
            spread_zero  = 1'b0;
            width_reg    = CFG_W_BITS'(CFG_SIZE_RST);
            height_reg   = CFG_H_BITS'(CFG_SIZE_RST);
            next_col     = 0;
            next_row     = 0;
            in_flight    = 0;
            dilated_q.delete();
            o_fail_count = 0;
        end else begin
            // register writes
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PAINT_MODE:   spread_zero = i_cfg_data[0];
                    CFG_IMAGE_WIDTH:  width_reg   = i_cfg_data[CFG_W_BITS-1:0];
                    CFG_IMAGE_HEIGHT: height_reg  = i_cfg_data[CFG_H_BITS-1:0];
                    default: ;
                endcase
            end
            // request side
            if (i_in_valid && i_in_ready) take_request(i_op, i_pixel_in);
            // result side
            if (i_out_valid && i_out_ready) begin
                if (dilated_q.size() == 0) begin
                    $display("%0t: result with none expected, pixel_out %0d frame_last %0d",
                             $time, i_pixel_out, i_frame_last);
                    o_fail_count++;
                end else begin
                    want = dilated_q.pop_front();
                    if (i_pixel_out !== want.pixel) begin
                        $display("%0t: pixel_out expected %0d actual %0d",
                                 $time, want.pixel, i_pixel_out);
                        o_fail_count++;
                    end
                    if (i_frame_last !== want.last) begin
                        $display("%0t: frame_last expected %0d actual %0d",
                                 $time, want.last, i_frame_last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_waiting <= dilated_q.size();
    end

endmodule

[sim/diagonal_binary_morphology_test.sv]
// ----------------------------------------------------------------------------
// diagonal_binary_morphology_test
// Drives pixel and drain requests into the diagonal morphology block under
// changing paint modes and image sizes, with random stalls on both channels,
// and gives the verdict from the failure count and open results of the result checker.
// ----------------------------------------------------------------------------
module diagonal_binary_morphology_test import dbm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   MAX_W        = 1024;
    localparam int   MAX_H        = 4096;
    localparam int   RANDOM_ITEMS = 1300;
    localparam int   CYCLE_LIMIT  = 600_000;
    localparam logic OP_DRAIN     = ~OP_PIXEL;

    // small image with both trigger values and near-extreme gray levels
    localparam logic [PIX_W-1:0] SEED_IMAGE [9] = '{
        8'hFF, 8'h00, 8'h01,
        8'h80, 8'hFE, 8'h7F,
        8'h00, 8'hFF, 8'h00
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic                  i_op        = OP_PIXEL;
    logic [PIX_W-1:0]      i_pixel_in  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_frame_last;

    int          waiting;
    int          fail_count;
    int          send_idle  = 0;
    int          recv_idle  = 0;
    int          cycles     = 0;
    int          live_items = 0;
    int unsigned img_w      = 1;
    int unsigned img_h      = 1;

    always #5ns i_clk = ~i_clk;

    diagonal_binary_morphology #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_pixel_in   (i_pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last)
    );

    dbm_result_checker #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_pixel_in   (i_pixel_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_pixel_out  (o_pixel_out),
        .i_frame_last (o_frame_last),
        .o_waiting    (waiting),
        .o_fail_count (fail_count)
    );

    // result side stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL diagonal_binary_morphology");
            $finish;
        end
    end

    // one request, with a random gap in front of it
    task automatic push_request(input logic op, input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // hold requests until every predicted result is out, then let the block settle
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (waiting != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // all three registers, back to back; block must be idle
    task automatic load_setup(input logic mode, input int unsigned w_raw,
                              input int unsigned h_raw);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_PAINT_MODE;
        i_cfg_data  <= CFG_DATA_W'(mode);
        @(posedge i_clk);
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= CFG_DATA_W'(w_raw);
        @(posedge i_clk);
        i_cfg_index <= CFG_IMAGE_HEIGHT;
        i_cfg_data  <= CFG_DATA_W'(h_raw);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        img_w = (w_raw == 0) ? 1 : ((w_raw > MAX_W) ? MAX_W : w_raw);
        img_h = (h_raw == 0) ? 1 : ((h_raw > MAX_H) ? MAX_H : h_raw);
    endtask

    // mostly binary pixels, some gray
    function automatic logic [PIX_W-1:0] pick_pixel(input int ones);
        int unsigned r;
        r = $urandom_range(99);
        if (r < ones) return 8'hFF;
        if (r < 90) return 8'h00;
        return PIX_W'($urandom);
    endfunction

    // one whole image and the drains that flush it
    task automatic stream_image(input int ones, input bit noisy);
        int unsigned total, held, k;
        total = img_w * img_h;
        held  = (total < img_w + 1) ? total : img_w + 1;
        // drain with nothing pending
        if (noisy && $urandom_range(99) < 15) push_request(OP_DRAIN, PIX_W'($urandom));
        for (k = 0; k < total; k++) begin
            // early drain, ignored
            if (noisy && $urandom_range(99) < 3) push_request(OP_DRAIN, PIX_W'($urandom));
            if (noisy && $urandom_range(999) < 4) settle();
            push_request(OP_PIXEL, pick_pixel(ones));
        end
        // flush, now and then with a surplus pixel in place of a drain
        for (k = 0; k < held; k++) begin
            if (noisy && $urandom_range(99) < 10)
                push_request(OP_PIXEL, PIX_W'($urandom));
            else
                push_request(OP_DRAIN, PIX_W'($urandom));
        end
        live_items += total + held;
    endtask

    initial begin
        int unsigned k, wr, hr;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 3x3 image with edges, stray drains and a surplus pixel
        send_idle = 12;
        recv_idle <= 64;
        load_setup(1'b0, 3, 3);
        push_request(OP_DRAIN, 8'h00);
        for (k = 0; k < 9; k++) begin
            if (k == 6) begin
                settle();
                push_request(OP_DRAIN, 8'hFF);
            end
            push_request(OP_PIXEL, SEED_IMAGE[k]);
        end
        push_request(OP_DRAIN, 8'h00);
        push_request(OP_PIXEL, 8'hAA);
        push_request(OP_DRAIN, 8'h00);
        push_request(OP_DRAIN, 8'h00);
        push_request(OP_DRAIN, 8'h00);

        // directed: zero sizes act as a single pixel, spreading zero
        settle();
        load_setup(1'b1, 0, 0);
        push_request(OP_PIXEL, 8'h00);
        push_request(OP_DRAIN, 8'h00);
        push_request(OP_PIXEL, 8'h4D);
        push_request(OP_DRAIN, 8'h00);

        // random images, idle pattern shifting by thirds
        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            if (live_items < RANDOM_ITEMS / 3) begin
                send_idle = 12;
                recv_idle <= 64;
            end else if (live_items < 2 * RANDOM_ITEMS / 3) begin
                send_idle = 64;
                recv_idle <= 12;
            end else begin
                send_idle = 0;
                recv_idle <= 0;
            end
            if ($urandom_range(1) == 1) begin
                k  = $urandom_range(99);
                wr = (k < 5) ? 0 : ((k < 10) ? $urandom_range(17, 40) : $urandom_range(1, 16));
                hr = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 8);
                settle();
                load_setup(1'($urandom), wr, hr);
            end
            stream_image($urandom_range(10, 60), 1'b1);
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && waiting == 0)
            $display("PASS diagonal_binary_morphology");
        else
            $display("FAIL diagonal_binary_morphology");
        $finish;
    end

endmodule
